FILE: rtl/core/btp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btp_pkg
// Shared types and constants of the byte to pulse run encoder.
// ----------------------------------------------------------------------------
package btp_pkg;

    localparam int DURATION_BITS = 15;
    localparam logic [DURATION_BITS-1:0] TICK_MAX = {DURATION_BITS{1'b1}};

    localparam int BYTE_W  = 8;
    localparam int BIT_IDX_W = $clog2(BYTE_W);
    localparam logic [BIT_IDX_W-1:0] LAST_BIT_IDX = BIT_IDX_W'(BYTE_W - 1);

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = DURATION_BITS;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BIT_DURATION = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_IDLE_LEVEL   = 4'd1;

    localparam logic [DURATION_BITS-1:0] BIT_DURATION_RESET = DURATION_BITS'(833);
    localparam logic IDLE_LEVEL_RESET = 1'b1;

    // mod-3 bit phase counter
    localparam logic [1:0] PHASE_EXTRA = 2'd1;
    localparam logic [1:0] PHASE_LAST  = 2'd2;

    // input word queue between front and back, power of two deep
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              frame_end;
    } t_item;

    typedef struct packed {
        logic                     pulse_level;
        logic [DURATION_BITS-1:0] pulse_ticks;
        logic                     end_mark;
    } t_pulse;

    typedef struct packed {
        logic [DURATION_BITS-1:0] bit_duration;
        logic                     idle_level;
    } t_cfg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BITS,
        ST_FLUSH,
        ST_MARK
    } t_back_state;

endpackage
`default_nettype wire

FILE: rtl/core/btp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btp_if
// Valid/ready channels: input bytes, output pulses, configuration writes.
// ----------------------------------------------------------------------------
interface btp_byte_if;
    logic                     valid;
    logic                     ready;
    logic [btp_pkg::BYTE_W-1:0] data_byte;
    logic                     frame_end;

    modport source (output valid, output data_byte, output frame_end, input ready);
    modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

interface btp_pulse_if;
    logic                              valid;
    logic                              ready;
    logic                              pulse_level;
    logic [btp_pkg::DURATION_BITS-1:0] pulse_ticks;
    logic                              end_mark;

    modport source (output valid, output pulse_level, output pulse_ticks,
                    output end_mark, input ready);
    modport sink   (input valid, input pulse_level, input pulse_ticks,
                    input end_mark, output ready);
endinterface

interface btp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [btp_pkg::CFG_IDX_W-1:0]  index;
    logic [btp_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/byte_to_pulse_run_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// A byte accepted into an idle block reaches the output through the queue, byte and output registers.
// Throughput: the bit engine handles one bit per cycle, adding flush and end mark
// steps after the last byte of a frame; the output register stalls it.
// A two-word queue decouples input acceptance from the bit engine.
// Reset (synchronous, active low): bit_duration 833, idle_level 1, open run at
// idle level with one bit time, phase 0, queue and output empty.
// ----------------------------------------------------------------------------
// byte_to_pulse_run_encoder
// NRZ byte stream to (level, ticks) run pulses with frame end marks.
// ----------------------------------------------------------------------------
module byte_to_pulse_run_encoder (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    btp_byte_if.sink   i_byte,
    btp_cfg_if.sink    i_cfg,
    btp_pulse_if.source o_pulse
);
    import btp_pkg::*;

    t_item  in_item;
    t_cfg   cfg;
    logic   q_valid;
    t_item  q_item;
    logic   q_pop;
    t_pulse pulse;

    assign in_item.data_byte = i_byte.data_byte;
    assign in_item.frame_end = i_byte.frame_end;

    btp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_byte.valid),
        .o_ready     (i_byte.ready),
        .i_item      (in_item),
        .i_cfg_valid (i_cfg.valid),
        .o_cfg_ready (i_cfg.ready),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_cfg       (cfg),
        .o_q_valid   (q_valid),
        .o_q_item    (q_item),
        .i_q_pop     (q_pop)
    );

    btp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_valid   (o_pulse.valid),
        .i_ready   (o_pulse.ready),
        .o_pulse   (pulse)
    );

    assign o_pulse.pulse_level = pulse.pulse_level;
    assign o_pulse.pulse_ticks = pulse.pulse_ticks;
    assign o_pulse.end_mark    = pulse.end_mark;

endmodule
`default_nettype wire

FILE: rtl/core/btp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btp_front
// Configuration registers and the input word queue feeding the bit engine.
// ----------------------------------------------------------------------------
module btp_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire btp_pkg::t_item                 i_item,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [btp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [btp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output btp_pkg::t_cfg                       o_cfg,
    output logic                                o_q_valid,
    output btp_pkg::t_item                      o_q_item,
    input  wire logic                           i_q_pop
);
    import btp_pkg::*;

    t_item             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    t_cfg              r_cfg;
    logic              push;

    assign o_ready     = (r_count != (QPTR_W+1)'(QDEPTH));
    assign o_cfg_ready = 1'b1;
    assign push        = i_valid && o_ready;
    assign o_q_valid   = (r_count != '0);
    assign o_q_item    = r_mem[r_rd_ptr];
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_cfg.bit_duration <= BIT_DURATION_RESET;
            r_cfg.idle_level   <= IDLE_LEVEL_RESET;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_q_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, i_q_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_IDX_BIT_DURATION) begin
                    r_cfg.bit_duration <= i_cfg_data[DURATION_BITS-1:0];
                end else if (i_cfg_index == CFG_IDX_IDLE_LEVEL) begin
                    r_cfg.idle_level <= i_cfg_data[0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/btp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btp_back
// Bit engine: one bit per cycle when not stalled, run merging, flush and end mark, output register.
// ----------------------------------------------------------------------------
module btp_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire btp_pkg::t_cfg  i_cfg,
    input  wire logic           i_q_valid,
    input  wire btp_pkg::t_item i_q_item,
    output logic                o_q_pop,
    output logic                o_valid,
    input  wire logic           i_ready,
    output btp_pkg::t_pulse     o_pulse
);
    import btp_pkg::*;

    t_back_state              r_state, n_state;
    logic [BYTE_W-1:0]        r_byte, n_byte;
    logic                     r_last, n_last;
    logic [BIT_IDX_W-1:0]     r_bit_idx, n_bit_idx;
    logic                     r_run_level, n_run_level;
    logic [DURATION_BITS-1:0] r_run_ticks, n_run_ticks;
    logic [1:0]               r_phase, n_phase;
    logic                     r_out_valid, n_out_valid;
    t_pulse                   r_out, n_out;

    logic                     step;
    logic                     cur_bit;
    logic [DURATION_BITS:0]   du_wide;
    logic [DURATION_BITS-1:0] du;
    logic [DURATION_BITS:0]   sum_wide;
    logic [DURATION_BITS-1:0] sum_sat;

    // output slot free now or emptied at this edge
    assign step    = !r_out_valid || i_ready;
    assign cur_bit = r_byte[r_bit_idx];
    assign o_valid = r_out_valid;
    assign o_pulse = r_out;

    always_comb begin
        du_wide  = {1'b0, i_cfg.bit_duration} + (DURATION_BITS+1)'(r_phase == PHASE_EXTRA);
        du       = (du_wide > {1'b0, TICK_MAX}) ? TICK_MAX : du_wide[DURATION_BITS-1:0];
        sum_wide = {1'b0, r_run_ticks} + {1'b0, du};
        sum_sat  = (sum_wide > {1'b0, TICK_MAX}) ? TICK_MAX : sum_wide[DURATION_BITS-1:0];
    end

    always_comb begin
        n_state     = r_state;
        n_byte      = r_byte;
        n_last      = r_last;
        n_bit_idx   = r_bit_idx;
        n_run_level = r_run_level;
        n_run_ticks = r_run_ticks;
        n_phase     = r_phase;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        o_q_pop     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                end
            end
            ST_BITS: begin
                if (step) begin
                    n_phase = (r_phase >= PHASE_LAST) ? 2'd0 : r_phase + 2'd1;
                    if (cur_bit == r_run_level) begin
                        n_run_ticks = sum_sat;
                    end else begin
                        n_out_valid = 1'b1;
                        n_out       = '{pulse_level: r_run_level, pulse_ticks: r_run_ticks,
                                        end_mark: 1'b0};
                        n_run_level = cur_bit;
                        n_run_ticks = du;
                    end
                    if (r_bit_idx == LAST_BIT_IDX) begin
                        if (r_last) begin
                            n_state = ST_FLUSH;
                        end else if (i_q_valid) begin
                            o_q_pop = 1'b1;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_bit_idx = r_bit_idx + 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                if (step) begin
                    // the run left open at frame end goes out unless it is idle
                    if (r_run_level != i_cfg.idle_level) begin
                        n_out_valid = 1'b1;
                        n_out       = '{pulse_level: r_run_level, pulse_ticks: r_run_ticks,
                                        end_mark: 1'b0};
                    end
                    n_state = ST_MARK;
                end
            end
            ST_MARK: begin
                if (step) begin
                    n_out_valid = 1'b1;
                    n_out       = '{pulse_level: 1'b0, pulse_ticks: '0, end_mark: 1'b1};
                    n_run_level = i_cfg.idle_level;
                    n_run_ticks = i_cfg.bit_duration;
                    n_phase     = 2'd0;
                    if (i_q_valid) begin
                        o_q_pop = 1'b1;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (o_q_pop) begin
            n_state   = ST_BITS;
            n_byte    = i_q_item.data_byte;
            n_last    = i_q_item.frame_end;
            n_bit_idx = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_bit_idx   <= '0;
            r_run_level <= IDLE_LEVEL_RESET;
            r_run_ticks <= BIT_DURATION_RESET;
            r_phase     <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bit_idx   <= n_bit_idx;
            r_run_level <= n_run_level;
            r_run_ticks <= n_run_ticks;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_last <= n_last;
        r_out  <= n_out;
    end

`ifndef SYNTHESIS
    a_mark_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.end_mark) |-> (!r_out.pulse_level && r_out.pulse_ticks == '0))
        else $error("end mark word carries nonzero level or ticks");

    a_flush_to_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH && step) |=> (r_state == ST_MARK))
        else $error("flush not followed by end mark");

    a_idle_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> i_q_valid)
        else $error("pop from empty queue");

    a_idle_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MARK && step) |=> (r_phase == 2'd0 || r_state == ST_BITS))
        else $error("bit phase not restarted after frame end");
`endif

endmodule
`default_nettype wire
